[sv/assert_macros.svh]
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[sv/pdps_pkg.sv]
`default_nettype none

package pdps_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int SAMPLE_BITS_DEF   = 16;

    localparam int NUM_CELLS = 30;
    localparam int TRIG_W    = 34;
    localparam int ZW        = 33;
    localparam int RAD_W     = 60;
    localparam int R_W       = 32;
    localparam int PROD_W    = 64;
    localparam int Q15_W     = 16;
    localparam int PADDR_W   = 2;
    localparam int PDATA_W   = 32;

    localparam logic [PADDR_W-1:0] ADDR_RADIUS_MODE = 2'd0;

    localparam int CORDIC_GAIN_Q30 = 652032874;

    typedef struct packed {
        logic signed [TRIG_W-1:0] x;
        logic signed [TRIG_W-1:0] y;
        logic signed [ZW-1:0]     z;
        logic [1:0]               quad;
        logic [RAD_W-1:0]         rem;
        logic [RAD_W-1:0]         root;
        logic signed [R_W-1:0]    r1;
    } cell_data_t;

    function automatic logic [30:0] atan_turn(input int idx);
        logic [30:0] v;
        case (idx)
            0:       v = 31'd536870912;
            1:       v = 31'd316933406;
            2:       v = 31'd167458907;
            3:       v = 31'd85004756;
            4:       v = 31'd42667331;
            5:       v = 31'd21354465;
            6:       v = 31'd10679838;
            7:       v = 31'd5340245;
            8:       v = 31'd2670163;
            9:       v = 31'd1335087;
            10:      v = 31'd667544;
            11:      v = 31'd333772;
            12:      v = 31'd166886;
            13:      v = 31'd83443;
            14:      v = 31'd41722;
            15:      v = 31'd20861;
            16:      v = 31'd10430;
            17:      v = 31'd5215;
            18:      v = 31'd2608;
            19:      v = 31'd1304;
            20:      v = 31'd652;
            21:      v = 31'd326;
            22:      v = 31'd163;
            23:      v = 31'd81;
            default: v = 31'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[sv/pdps_if.sv]
`default_nettype none

interface pdps_sample_if #(
    parameter int SAMPLE_BITS = pdps_pkg::SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] angle_sample;
    logic [SAMPLE_BITS-1:0] radius_sample;

    modport source (output valid, angle_sample, radius_sample, input ready);
    modport sink   (input valid, angle_sample, radius_sample, output ready);
endinterface

interface pdps_point_if;
    logic                               valid;
    logic                               ready;
    logic signed [pdps_pkg::Q15_W-1:0]  point_x;
    logic signed [pdps_pkg::Q15_W-1:0]  point_y;

    modport source (output valid, point_x, point_y, input ready);
    modport sink   (input valid, point_x, point_y, output ready);
endinterface

`default_nettype wire

[sv/pdps_cell.sv]
`default_nettype none

module pdps_cell #(
    parameter int IDX           = 0,
    parameter int CORDIC_STAGES = pdps_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire pdps_pkg::cell_data_t in_data,
    output logic                      out_valid,
    output pdps_pkg::cell_data_t      out_data
);
    import pdps_pkg::*;

    localparam int               SQRT_SHIFT = RAD_W - 2 - 2 * IDX;
    localparam logic [RAD_W-1:0] SQRT_BIT   = RAD_W'(1) << SQRT_SHIFT;
    localparam logic [ZW-1:0]    ATAN       = {2'b00, atan_turn(IDX)};
    localparam bit               DO_ROT     = (IDX < CORDIC_STAGES);

    logic        valid_reg;
    cell_data_t  data_reg;
    cell_data_t  data_next;

    logic signed [TRIG_W-1:0] dx;
    logic signed [TRIG_W-1:0] dy;
    logic [RAD_W:0]           trial;

    always_comb
    begin
        data_next = in_data;
        dx        = in_data.y >>> IDX;
        dy        = in_data.x >>> IDX;
        if (DO_ROT)
        begin
            if (!in_data.z[ZW-1])
            begin
                data_next.x = in_data.x - dx;
                data_next.y = in_data.y + dy;
                data_next.z = in_data.z - $signed(ATAN);
            end
            else
            begin
                data_next.x = in_data.x + dx;
                data_next.y = in_data.y - dy;
                data_next.z = in_data.z + $signed(ATAN);
            end
        end
        trial = {1'b0, in_data.root} + {1'b0, SQRT_BIT};
        if ({1'b0, in_data.rem} >= trial)
        begin
            data_next.rem  = in_data.rem - trial[RAD_W-1:0];
            data_next.root = (in_data.root >> 1) + SQRT_BIT;
        end
        else
        begin
            data_next.root = in_data.root >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

[sv/polar_disk_point_sampler_unit.sv]
// Maps two uniform samples to a point in the unit disk, as signed Q1.15 x and y. The angle
// sample is a fraction of a full turn; radius_mode selects a radius of sqrt(sample), which is
// uniform by area, or one minus twice the sample. A row of 30 cells carries each beat, every
// cell doing one CORDIC rotation (while within CORDIC_STAGES) and one square-root digit, then
// one multiply stage and one rounding stage follow. One beat is accepted in every cycle while
// the output is being taken; the 30-digit square root sets the length of the row. A stalled
// output holds the whole row.
`default_nettype none

`include "assert_macros.svh"

module polar_disk_point_sampler_unit #(
    parameter int CORDIC_STAGES = pdps_pkg::CORDIC_STAGES_DEF,
    parameter int SAMPLE_BITS   = pdps_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [pdps_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [pdps_pkg::PDATA_W-1:0]   pwdata,
    output logic [pdps_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready,
    pdps_sample_if.sink                         sample,
    pdps_point_if.source                        point
);
    import pdps_pkg::*;

    logic adv;
    logic cfg_write;
    logic mode_write;
    logic radius_mode_reg;

    logic       cell_valid [NUM_CELLS+1];
    cell_data_t cell_data  [NUM_CELLS+1];
    cell_data_t entry_data;

    logic [31:0]  phase;
    logic [R_W-1:0] r1_raw;

    logic signed [R_W-1:0]    c_val;
    logic signed [R_W-1:0]    s_val;
    logic signed [TRIG_W-1:0] neg_x;
    logic signed [TRIG_W-1:0] neg_y;
    logic signed [R_W-1:0]    radius;

    logic                     mul_valid_reg;
    logic signed [PROD_W-1:0] prod_x_reg;
    logic signed [PROD_W-1:0] prod_y_reg;
    logic signed [PROD_W-1:0] prod_x_next;
    logic signed [PROD_W-1:0] prod_y_next;

    logic                     out_valid_reg;
    logic signed [Q15_W-1:0]  point_x_reg;
    logic signed [Q15_W-1:0]  point_y_reg;
    logic signed [Q15_W-1:0]  point_x_next;
    logic signed [Q15_W-1:0]  point_y_next;

    function automatic logic signed [Q15_W-1:0] to_q15(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] q;
        logic signed [Q15_W-1:0]  r;
        q = (p + (PROD_W'(1) <<< 44)) >>> 45;
        if (q > PROD_W'(32767))
        begin
            r = 16'sh7fff;
        end
        else if (q < -PROD_W'(32768))
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = q[Q15_W-1:0];
        end
        return r;
    endfunction

    assign adv          = !out_valid_reg || point.ready;
    assign sample.ready = adv;

    // Configuration port.
    assign pready     = 1'b1;
    assign cfg_write  = psel && penable && pwrite && pready;
    assign mode_write = cfg_write && (paddr == ADDR_RADIUS_MODE);
    assign prdata     = (paddr == ADDR_RADIUS_MODE) ? {{(PDATA_W-1){1'b0}}, radius_mode_reg}
                                                    : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_mode_reg <= 1'b0;
        end
        else if (mode_write)
        begin
            radius_mode_reg <= pwdata[0];
        end
    end

    // Entry into the row of cells.
    assign phase  = 32'(sample.angle_sample) << (32 - SAMPLE_BITS);
    assign r1_raw = (R_W'(1) << 30) - (R_W'(sample.radius_sample) << (31 - SAMPLE_BITS));

    always_comb
    begin
        entry_data.x    = TRIG_W'(CORDIC_GAIN_Q30);
        entry_data.y    = '0;
        entry_data.z    = {3'b000, phase[29:0]};
        entry_data.quad = phase[31:30];
        entry_data.rem  = RAD_W'(sample.radius_sample) << (RAD_W - SAMPLE_BITS);
        entry_data.root = '0;
        entry_data.r1   = $signed(r1_raw);
    end

    assign cell_valid[0] = sample.valid;
    assign cell_data[0]  = entry_data;

    for (genvar k = 0; k < NUM_CELLS; k++)
    begin : g_cell
        pdps_cell #(
            .IDX           (k),
            .CORDIC_STAGES (CORDIC_STAGES)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (cell_valid[k]),
            .in_data   (cell_data[k]),
            .out_valid (cell_valid[k+1]),
            .out_data  (cell_data[k+1])
        );
    end

    // Quadrant fold and radius multiply.
    always_comb
    begin
        neg_x = -cell_data[NUM_CELLS].x;
        neg_y = -cell_data[NUM_CELLS].y;
        case (cell_data[NUM_CELLS].quad)
            2'd0:
            begin
                c_val = cell_data[NUM_CELLS].x[R_W-1:0];
                s_val = cell_data[NUM_CELLS].y[R_W-1:0];
            end
            2'd1:
            begin
                c_val = neg_y[R_W-1:0];
                s_val = cell_data[NUM_CELLS].x[R_W-1:0];
            end
            2'd2:
            begin
                c_val = neg_x[R_W-1:0];
                s_val = neg_y[R_W-1:0];
            end
            default:
            begin
                c_val = cell_data[NUM_CELLS].y[R_W-1:0];
                s_val = neg_x[R_W-1:0];
            end
        endcase
        radius = radius_mode_reg ? cell_data[NUM_CELLS].r1
                                 : $signed({2'b00, cell_data[NUM_CELLS].root[29:0]});
        prod_x_next = c_val * radius;
        prod_y_next = s_val * radius;
    end

    assign point_x_next = to_q15(prod_x_reg);
    assign point_y_next = to_q15(prod_y_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            mul_valid_reg <= cell_valid[NUM_CELLS];
            out_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_x_reg  <= prod_x_next;
            prod_y_reg  <= prod_y_next;
            point_x_reg <= point_x_next;
            point_y_reg <= point_y_next;
        end
    end

    assign point.valid   = out_valid_reg;
    assign point.point_x = point_x_reg;
    assign point.point_y = point_y_reg;

    `ASSERT_NEXT(a_entry, clk, rst_n, sample.valid && sample.ready, cell_valid[1])
    `ASSERT_NEXT(a_mul_to_out, clk, rst_n, mul_valid_reg && adv, point.valid)
    `ASSERT_NEXT(a_cfg, clk, rst_n, mode_write, radius_mode_reg == $past(pwdata[0]))
    `ASSERT_IMPLIES(a_ready, clk, rst_n, point.valid && !point.ready, !sample.ready)

endmodule

`default_nettype wire

[tb/sv/pdps_test_pkg.sv]
`timescale 1ns / 1ps

package pdps_test_pkg;

    typedef enum logic {
        RADIUS_SQRT = 1'b0,
        RADIUS_LINE = 1'b1
    } radius_mode_e;

endpackage

[tb/sv/pdps_point_checker.sv]
`timescale 1ns / 1ps

module pdps_point_checker #(
    parameter int CORDIC_STAGES = pdps_pkg::CORDIC_STAGES_DEF,
    parameter int SAMPLE_BITS   = pdps_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic                           pready,
    input  wire logic [pdps_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [pdps_pkg::PDATA_W-1:0]   pwdata,
    input  wire logic [pdps_pkg::PDATA_W-1:0]   prdata,
    pdps_sample_if                              sample,
    pdps_point_if                               point,
    output int                                  failures,
    output int                                  pending,
    output int                                  points_checked
);
    import pdps_pkg::*;
    import pdps_test_pkg::*;

    localparam int     SB        = SAMPLE_BITS;
    localparam int     STAGES    = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;
    localparam int     REPORTED  = 10;
    localparam longint GAIN_Q30  = 652032874;

    localparam longint ROT_STEP [0:23] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    typedef enum logic [1:0] {
        QUAD_FIRST,
        QUAD_SECOND,
        QUAD_THIRD,
        QUAD_FOURTH
    } quadrant_e;

    typedef struct packed {
        logic signed [Q15_W-1:0] x;
        logic signed [Q15_W-1:0] y;
    } disk_point_t;

    radius_mode_e rule;
    disk_point_t  expected_points [$];
    disk_point_t  oldest;

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned rest;
        longint unsigned root;
        longint unsigned bitv;
        rest = v;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > rest && bitv != 0)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (rest >= root + bitv)
            begin
                rest = rest - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic logic signed [Q15_W-1:0] scale_q15(input longint trig,
                                                          input longint rad);
        longint p;
        p = (trig * rad + (64'sd1 <<< 44)) >>> 45;
        if (p > 32767)
            p = 32767;
        if (p < -32768)
            p = -32768;
        return Q15_W'(p);
    endfunction

    function automatic disk_point_t predict_point(input logic [SB-1:0] ang,
                                                  input logic [SB-1:0] rs,
                                                  input radius_mode_e mode);
        logic [31:0] phase;
        longint      x;
        longint      y;
        longint      z;
        longint      dx;
        longint      dy;
        longint      c;
        longint      s;
        longint      r;
        disk_point_t pt;
        phase = 32'(ang) << (32 - SB);
        x = GAIN_Q30;
        y = 0;
        z = {34'd0, phase[29:0]};
        for (int i = 0; i < STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - ROT_STEP[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + ROT_STEP[i];
            end
        end
        case (quadrant_e'(phase[31:30]))
            QUAD_FIRST:
            begin
                c = x;
                s = y;
            end
            QUAD_SECOND:
            begin
                c = -y;
                s = x;
            end
            QUAD_THIRD:
            begin
                c = -x;
                s = -y;
            end
            default:
            begin
                c = y;
                s = -x;
            end
        endcase
        if (mode == RADIUS_SQRT)
            r = longint'(root_floor(64'(rs) << (60 - SB)));
        else
            r = (64'sd1 <<< 30) - longint'(64'(rs) << (31 - SB));
        pt.x = scale_q15(c, r);
        pt.y = scale_q15(s, r);
        return pt;
    endfunction

    task automatic flag(input string msg);
        failures++;
        if (failures <= REPORTED)
            $display("%0t: %s", $realtime, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rule <= RADIUS_SQRT;
        else if (psel && penable && pwrite && pready && paddr == ADDR_RADIUS_MODE)
            rule <= radius_mode_e'(pwdata[0]);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (psel && penable && !pwrite && pready && paddr == ADDR_RADIUS_MODE
                && prdata !== PDATA_W'(rule))
                flag($sformatf("radius_mode read: expected %0d, got %0h", rule, prdata));
            if (sample.valid && sample.ready)
                expected_points.push_back(predict_point(sample.angle_sample,
                                                        sample.radius_sample, rule));
            if (point.valid && point.ready)
            begin
                if (expected_points.size() == 0)
                    flag($sformatf("point (%0d, %0d) arrived with no sample outstanding",
                                   point.point_x, point.point_y));
                else
                begin
                    oldest = expected_points.pop_front();
                    if (point.point_x !== oldest.x)
                        flag($sformatf("point_x: expected %0d, got %0d",
                                       oldest.x, point.point_x));
                    if (point.point_y !== oldest.y)
                        flag($sformatf("point_y: expected %0d, got %0d",
                                       oldest.y, point.point_y));
                    points_checked++;
                end
            end
        end
        pending = expected_points.size();
    end

endmodule

[tb/sv/polar_disk_point_sampler_unit_test.sv]
`timescale 1ns / 1ps

module polar_disk_point_sampler_unit_test;
    import pdps_pkg::*;
    import pdps_test_pkg::*;

    localparam int SB            = SAMPLE_BITS_DEF;
    localparam int IDLE_PERCENT  = 32;
    localparam int PHASES        = 4;
    localparam int PHASE_ITEMS   = 225;
    localparam int TX_STEADY_LO  = 550;
    localparam int TX_STEADY_HI  = 700;
    localparam int RX_STEADY_LO  = 600;
    localparam int RX_STEADY_HI  = 760;
    localparam int HOLD_AT       = 400;
    localparam int LONG_HOLD     = 300;
    localparam int DRAIN_CYCLES  = 64;
    localparam int CYCLE_LIMIT   = 60000;

    localparam logic [SB-1:0] DIRECTED_ANGLE [0:11] = '{
        16'h0000, 16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF,
        16'h0001, 16'h2000, 16'h5555, 16'hE000, 16'h3FFF, 16'h7FFF
    };
    localparam logic [SB-1:0] DIRECTED_RADIUS [0:11] = '{
        16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h8000, 16'h0001,
        16'hFFFF, 16'h4000, 16'h7FFF, 16'hC000, 16'h8001, 16'hFFFF
    };

    typedef enum logic {
        APB_READ,
        APB_WRITE
    } apb_dir_e;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int failures;
    int pending;
    int points_checked;
    int samples_sent = 0;
    int reg_writes = 0;
    int cycle_count = 0;
    int results_taken = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    pdps_sample_if #(.SAMPLE_BITS(SB)) sample_ch ();
    pdps_point_if                      point_ch ();

    polar_disk_point_sampler_unit #(
        .CORDIC_STAGES(CORDIC_STAGES_DEF),
        .SAMPLE_BITS(SB)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .sample(sample_ch),
        .point(point_ch)
    );

    pdps_point_checker #(
        .CORDIC_STAGES(CORDIC_STAGES_DEF),
        .SAMPLE_BITS(SB)
    ) point_check (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .pready(pready),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .sample(sample_ch),
        .point(point_ch),
        .failures(failures),
        .pending(pending),
        .points_checked(points_checked)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timed out with %0d points still outstanding.", pending);
            $display("polar_disk_point_sampler_unit_test NOT OK");
            $finish;
        end
    end

    task automatic reg_access(input apb_dir_e dir, input logic [PADDR_W-1:0] addr,
                              input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= (dir == APB_WRITE);
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (dir == APB_WRITE)
            reg_writes++;
        @(posedge clk);
    endtask

    task automatic set_rule(input radius_mode_e rule);
        reg_access(APB_WRITE, ADDR_RADIUS_MODE, ($urandom & ~32'd1) | PDATA_W'(rule));
        reg_access(APB_READ, ADDR_RADIUS_MODE, '0);
    endtask

    task automatic send_item(input logic [SB-1:0] ang, input logic [SB-1:0] rs);
        bit steady;
        steady = (samples_sent >= TX_STEADY_LO && samples_sent < TX_STEADY_HI);
        while (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid         <= 1'b1;
        sample_ch.angle_sample  <= ang;
        sample_ch.radius_sample <= rs;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        samples_sent++;
    endtask

    // The sender stays quiet until every outstanding point has been taken.
    task automatic settle();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Mostly uniform, with some weight on zero, full scale and quadrant boundaries.
    function automatic logic [SB-1:0] rand_sample();
        logic [SB-1:0] v;
        if ($urandom_range(99) < 12)
        begin
            v = {2'($urandom_range(3)), {(SB-2){1'b0}}};
            v = v + SB'($urandom_range(2)) - SB'(1);
        end
        else
            v = SB'($urandom);
        return v;
    endfunction

    initial
    begin
        rst_n                   <= 1'b0;
        psel                    <= 1'b0;
        penable                 <= 1'b0;
        pwrite                  <= 1'b0;
        paddr                   <= '0;
        pwdata                  <= '0;
        sample_ch.valid         <= 1'b0;
        sample_ch.angle_sample  <= '0;
        sample_ch.radius_sample <= '0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        reg_access(APB_READ, ADDR_RADIUS_MODE, '0);
        foreach (DIRECTED_ANGLE[i])
            send_item(DIRECTED_ANGLE[i], DIRECTED_RADIUS[i]);
        settle();
        set_rule(RADIUS_LINE);
        foreach (DIRECTED_ANGLE[i])
            send_item(DIRECTED_ANGLE[i], DIRECTED_RADIUS[i]);
        settle();

        // Writes to any other address must leave the radius rule alone.
        for (int a = 0; a < (1 << PADDR_W); a++)
        begin
            if (PADDR_W'(a) != ADDR_RADIUS_MODE)
                reg_access(APB_WRITE, PADDR_W'(a), $urandom & ~32'd1);
        end
        reg_access(APB_READ, ADDR_RADIUS_MODE, '0);

        for (int p = 0; p < PHASES; p++)
        begin
            set_rule(radius_mode_e'(p % 2));
            repeat (PHASE_ITEMS)
                send_item(rand_sample(), rand_sample());
            settle();
        end

        repeat (DRAIN_CYCLES)
            @(posedge clk);
        $display("Checked %0d points from %0d sample beats under both radius rules,",
                 points_checked, samples_sent);
        $display("with %0d register writes and a %0d-cycle stall on the point output.",
                 reg_writes, LONG_HOLD);
        if (failures == 0)
            $display("polar_disk_point_sampler_unit_test OK");
        else
            $display("polar_disk_point_sampler_unit_test NOT OK");
        $finish;
    end

    initial
    begin
        point_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (point_ch.valid && point_ch.ready)
                results_taken++;
            if (hold_left > 0)
            begin
                hold_left--;
                point_ch.ready <= 1'b0;
            end
            else if (!hold_done && results_taken >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD - 1;
                point_ch.ready <= 1'b0;
            end
            else
                point_ch.ready <= (results_taken >= RX_STEADY_LO && results_taken < RX_STEADY_HI)
                                  || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

endmodule

[filelist.f]
+incdir+sv
sv/pdps_pkg.sv
sv/pdps_if.sv
sv/pdps_cell.sv
sv/polar_disk_point_sampler_unit.sv
tb/sv/pdps_test_pkg.sv
tb/sv/pdps_point_checker.sv
tb/sv/polar_disk_point_sampler_unit_test.sv
